### rtl/sccf_pkg.sv
// Shared types and constants for the sampled curve feature classifier.
`timescale 1ns / 1ps

package sccf_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned INDEX_W = 16;
    localparam int unsigned MODE_W  = 2;
    localparam int unsigned SLOTS   = 3;

    localparam logic [MODE_W-1:0] MODE_INFLECT = 2'd2;

    typedef enum logic [3:0] {
        KIND_START      = 4'd0,
        KIND_END        = 4'd1,
        KIND_MAX        = 4'd2,
        KIND_MIN        = 4'd3,
        KIND_MAX_AFTER  = 4'd4,
        KIND_MIN_AFTER  = 4'd5,
        KIND_MAX_BEFORE = 4'd6,
        KIND_MIN_BEFORE = 4'd7,
        KIND_INFLECT    = 4'd8
    } t_kind;

    typedef struct packed {
        logic [DATA_W-1:0] cmp;
        logic [DATA_W-1:0] disp;
        logic [DATA_W-1:0] slope;
        logic              valid;
    } t_sample;

    typedef struct packed {
        t_sample smp;
        logic    last_flag;
    } t_in_item;

    typedef struct packed {
        t_kind              kind;
        logic [INDEX_W-1:0] index;
        logic [DATA_W-1:0]  value;
    } t_result;

    typedef struct packed {
        logic [1:0]              cnt;
        t_result [SLOTS-1:0]     ent;
    } t_bundle;

endpackage

### rtl/sccf_classify.sv
// Three-point classifier: kind of a sample from its two neighbors.
`timescale 1ns / 1ps

module sccf_classify
    import sccf_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  t_sample i_cur,
    input  t_sample i_prev,
    input  t_sample i_next,
    input  logic    i_inflect_en,
    output logic    o_hit,
    output t_kind   o_kind
);

    // Widths above the field width compare the field as an unsigned number.
    localparam int KW = (VALUE_WIDTH <= DATA_W) ? VALUE_WIDTH : DATA_W + 1;

    logic signed [KW-1:0] kc, kp, kn, sc, sp, sn;
    logic gt_p, gt_n, lt_p, lt_n;

    assign kc = KW'(i_cur.cmp);
    assign kp = KW'(i_prev.cmp);
    assign kn = KW'(i_next.cmp);
    assign sc = KW'(i_cur.slope);
    assign sp = KW'(i_prev.slope);
    assign sn = KW'(i_next.slope);

    assign gt_p = kc > kp;
    assign lt_p = kc < kp;
    assign gt_n = kc > kn;
    assign lt_n = kc < kn;

    always_comb begin
        o_hit  = 1'b0;
        o_kind = KIND_START;
        if (i_cur.valid) begin
            if (!i_prev.valid && i_next.valid) begin
                if (gt_n) begin
                    o_hit  = 1'b1;
                    o_kind = KIND_MAX_AFTER;
                end else if (lt_n) begin
                    o_hit  = 1'b1;
                    o_kind = KIND_MIN_AFTER;
                end
            end else if (i_prev.valid && !i_next.valid) begin
                if (gt_p) begin
                    o_hit  = 1'b1;
                    o_kind = KIND_MAX_BEFORE;
                end else if (lt_p) begin
                    o_hit  = 1'b1;
                    o_kind = KIND_MIN_BEFORE;
                end
            end else if (i_prev.valid && i_next.valid) begin
                if (gt_p && gt_n) begin
                    o_hit  = 1'b1;
                    o_kind = KIND_MAX;
                end else if (lt_p && lt_n) begin
                    o_hit  = 1'b1;
                    o_kind = KIND_MIN;
                end else if (i_inflect_en &&
                             ((sc < sp && sc < sn) || (sc > sp && sc > sn))) begin
                    o_hit  = 1'b1;
                    o_kind = KIND_INFLECT;
                end
            end
        end
    end

endmodule

### rtl/sccf_result_q.sv
// Result buffer: holds the results of one sample and hands them out one by one.
`timescale 1ns / 1ps

module sccf_result_q
    import sccf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_bundle i_bundle,
    input  logic    i_take,
    output logic    o_can_load,
    output logic    o_valid,
    output logic    o_last,
    output t_result o_head
);

    t_result [SLOTS-1:0] r_q;
    t_result [SLOTS-1:0] n_q;
    logic [1:0]          r_cnt;
    logic [1:0]          n_cnt;

    // Free when empty or when the last held result leaves this cycle.
    assign o_can_load = (r_cnt == 2'd0) || (r_cnt == 2'd1 && i_take);
    assign o_valid    = r_cnt != 2'd0;
    assign o_last     = r_cnt == 2'd1;
    assign o_head     = r_q[0];

    always_comb begin
        n_q   = r_q;
        n_cnt = r_cnt;
        if (i_load) begin
            n_q   = i_bundle.ent;
            n_cnt = i_bundle.cnt;
        end else if (i_take) begin
            // advance the queue by one slot
            n_q[0] = r_q[1];
            n_q[1] = r_q[2];
            n_cnt  = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

endmodule

### rtl/sampled_curve_feature_classifier.sv
// Top level: sample window, classification and result output of the curve classifier.
`timescale 1ns / 1ps
//
//  channel  | direction | handshake                       | payload
//  ---------+-----------+---------------------------------+-------------------------------
//  sample   | in        | i_in_valid / o_in_stall         | compare, display, valid,
//           |           |                                 | slope, final flag
//  point    | out       | o_out_valid / i_out_stall       | kind, index, value, run_last
//  config   | in        | i_cfg_valid / o_cfg_ready       | i_cfg_data (derivative mode)
//
//  One sample transaction per cycle while o_in_stall is low. A sample waits in the
//  input register, is classified against the two-sample window and loads the result
//  buffer once the buffer can take it; its first result is on the port in the next
//  cycle, and the sample's results are taken while i_out_stall is low.
//  A sample causes at most three results (start or left-neighbor result, own result
//  on the final sample, end), one per slot of the three-slot result buffer, which
//  hands them out one by one and takes the next sample only as its last one leaves.
//  Reset (synchronous, active low) clears the window, the sample index, the
//  derivative mode and both valid flags. The config port is always ready.
//  Output stall backs up into o_in_stall only once the buffer and the input
//  register are both occupied.

module sampled_curve_feature_classifier
    import sccf_pkg::*;
#(
    parameter int MAX_SAMPLES = 65536,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,

    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic signed [DATA_W-1:0]  i_compare_value,
    input  logic signed [DATA_W-1:0]  i_display_value,
    input  logic                      i_sample_valid,
    input  logic signed [DATA_W-1:0]  i_slope_value,
    input  logic                      i_final_sample,

    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [3:0]                o_point_kind,
    output logic [INDEX_W-1:0]        o_point_index,
    output logic signed [DATA_W-1:0]  o_point_value,
    output logic                      o_run_last,

    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [MODE_W-1:0]         i_cfg_data
);

    localparam int CW = $clog2(MAX_SAMPLES);

    // Configuration
    logic [MODE_W-1:0] r_mode;

    // Input register
    logic     r_in_valid;
    t_in_item r_in;

    // Window and sample index
    t_sample       r_win0;
    t_sample       r_win1;
    logic [CW-1:0] r_count;

    // Handshake
    logic in_accept;
    logic out_take;
    logic can_load;
    logic load;

    // Classification
    t_sample            cur;
    t_sample            prev;
    t_sample            prev2;
    logic               first;
    logic               last;
    logic               inflect_en;
    logic               hit_prev;
    logic               hit_cur;
    t_kind              kind_prev;
    t_kind              kind_cur;
    logic [INDEX_W-1:0] idx16;
    t_result            c0, c1, c2;
    logic               v0, v1, v2;
    t_bundle            bundle;
    t_result            head;
    logic               q_valid;
    logic               q_last;

    assign o_cfg_ready = 1'b1;

    assign out_take   = o_out_valid && !i_out_stall;
    assign o_in_stall = r_in_valid && !can_load;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign load       = r_in_valid && can_load;

    // ---------------------------------------------------------------
    // Window selection. The first sample of a curve is its own left
    // neighbor, also when it is classified on the arrival of the second sample.
    // ---------------------------------------------------------------
    assign cur        = r_in.smp;
    assign first      = r_count == CW'(0);
    assign last       = r_in.last_flag || (r_count == CW'(MAX_SAMPLES - 1));
    assign prev       = first ? cur : r_win0;
    assign prev2      = (r_count == CW'(1)) ? r_win0 : r_win1;
    assign inflect_en = r_mode == MODE_INFLECT;
    assign idx16      = INDEX_W'(r_count);

    // Classify the previous sample now that its right neighbor is here.
    sccf_classify #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cls_prev (
        .i_cur        (prev),
        .i_prev       (prev2),
        .i_next       (cur),
        .i_inflect_en (inflect_en),
        .o_hit        (hit_prev),
        .o_kind       (kind_prev)
    );

    // Classify the final sample with itself as right neighbor.
    sccf_classify #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cls_cur (
        .i_cur        (cur),
        .i_prev       (prev),
        .i_next       (cur),
        .i_inflect_en (inflect_en),
        .o_hit        (hit_cur),
        .o_kind       (kind_cur)
    );

    // ---------------------------------------------------------------
    // Candidate results in emission order, then pack the valid ones
    // toward slot 0.
    // ---------------------------------------------------------------
    always_comb begin
        if (first) begin
            c0.kind  = KIND_START;
            c0.index = idx16;
            c0.value = cur.disp;
        end else begin
            c0.kind  = kind_prev;
            c0.index = idx16 - INDEX_W'(1);
            c0.value = prev.disp;
        end
        v0 = first || hit_prev;

        c1.kind  = kind_cur;
        c1.index = idx16;
        c1.value = cur.disp;
        v1       = last && hit_cur;

        c2.kind  = KIND_END;
        c2.index = idx16;
        c2.value = cur.disp;
        v2       = last;

        bundle.cnt    = {1'b0, v0} + {1'b0, v1} + {1'b0, v2};
        bundle.ent[0] = v0 ? c0 : (v1 ? c1 : c2);
        bundle.ent[1] = (v0 && v1) ? c1 : c2;
        bundle.ent[2] = c2;
    end

    sccf_result_q u_result_q (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_bundle   (bundle),
        .i_take     (out_take),
        .o_can_load (can_load),
        .o_valid    (q_valid),
        .o_last     (q_last),
        .o_head     (head)
    );

    assign o_out_valid   = q_valid;
    assign o_run_last    = q_last;
    assign o_point_kind  = head.kind;
    assign o_point_index = head.index;
    assign o_point_value = head.value;

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        // hold the input payload while the item waits for the buffer
        if (in_accept) begin
            r_in.smp.cmp   <= i_compare_value;
            r_in.smp.disp  <= i_display_value;
            r_in.smp.slope <= i_slope_value;
            r_in.smp.valid <= i_sample_valid;
            r_in.last_flag <= i_final_sample;
        end

        if (load && !last) begin
            r_win1.cmp   <= r_win0.cmp;
            r_win1.disp  <= r_win0.disp;
            r_win1.slope <= r_win0.slope;
            r_win0.cmp   <= cur.cmp;
            r_win0.disp  <= cur.disp;
            r_win0.slope <= cur.slope;
        end

        if (!i_rst_n) begin
            r_mode       <= '0;
            r_in_valid   <= 1'b0;
            r_count      <= '0;
            r_win0.valid <= 1'b0;
            r_win1.valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_mode <= i_cfg_data;
            end

            r_in_valid <= in_accept || (r_in_valid && !can_load);

            if (load) begin
                if (last) begin
                    // drop the window: next sample opens a new curve
                    r_count      <= '0;
                    r_win0.valid <= 1'b0;
                    r_win1.valid <= 1'b0;
                end else begin
                    r_count      <= CW'(r_count + CW'(1));
                    r_win1.valid <= r_win0.valid;
                    r_win0.valid <= cur.valid;
                end
            end
        end
    end

endmodule

### rtl/sccf_checker.sv
// Port-level checker for the curve classifier, with its bind.
`timescale 1ns / 1ps

module sccf_checker
    import sccf_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_in_stall,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input logic [3:0]                o_point_kind,
    input logic [INDEX_W-1:0]        o_point_index,
    input logic signed [DATA_W-1:0]  o_point_value,
    input logic                      o_run_last
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result pending right after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_point_kind) && $stable(o_point_index) &&
            $stable(o_point_value) && $stable(o_run_last))
        else $error("stalled result changed");

    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no result waiting");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_point_kind == KIND_END |-> o_run_last)
        else $error("end event not last result of its sample");

    a_start_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_point_kind == KIND_START |-> o_point_index == '0)
        else $error("start event with nonzero index");

endmodule

bind sampled_curve_feature_classifier sccf_checker u_sccf_checker (.*);
